// ===== rtl/core/selective_repeat_sender_window_macros.svh =====
// assertion macros for the selective repeat sender window
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_MACROS_SVH
`ifndef SYNTHESIS
`define SRSW_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SRSW_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRSW_ASSERT(label, clk, rst, prop, msg)
`define SRSW_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/srsw_pkg.sv =====
// shared types and constants of the selective repeat sender window
package srsw_pkg;
  localparam int WindowMax = 32;
  localparam int SeqBits = 16;
  localparam int SlotBits = $clog2(WindowMax);
  localparam int WinBits = $clog2(WindowMax + 1);
  localparam logic [15:0] TimeoutReset = 16'd10;
  localparam logic [5:0] WindowReset = 6'd8;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_ACK = 2'd1;
  localparam logic [1:0] REQ_POLL = 2'd2;
  localparam logic [1:0] REQ_TICK = 2'd3;

  localparam logic [0:0] REG_WINDOW = 1'b0;
  localparam logic [0:0] REG_TIMEOUT = 1'b1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [15:0] ack_seq;
    logic ack_negative;
    logic ack_error;
    logic [15:0] buffer_frames;
    logic final_buffer;
  } in_word_t;

  typedef struct packed {
    logic send_valid;
    logic [15:0] send_seq;
    logic end_of_transmission;
    logic last_of_pass;
    logic buffer_done;
  } out_word_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [SlotBits-1:0] slot;
    logic in_window;
    logic ack_negative;
    logic [15:0] buffer_frames;
    logic final_buffer;
  } cmd_t;
endpackage

// ===== rtl/core/selective_repeat_sender_window.sv =====
// selective repeat sender window: a start, ack or tick word is taken only while nothing
// is queued and the back is idle; a poll slides past acked slots and scans the window,
// and can be held off by the result side; it returns one or more words, the last one
// marked last_of_pass, and the next input word is taken only after the poll has finished
module selective_repeat_sender_window (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  srsw_pkg::in_word_t in_word,
  output logic out_valid,
  input  logic out_ready,
  output srsw_pkg::out_word_t out_word,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:2] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import srsw_pkg::*;
`include "selective_repeat_sender_window_macros.svh"
  logic [5:0] slot_count;
  logic [15:0] timeout_ticks;
  logic [WinBits-1:0] win;
  logic [15:0] window_base;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  logic poll_go;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= WindowReset;
      timeout_ticks <= TimeoutReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_WINDOW) slot_count <= pwdata[5:0];
      else timeout_ticks <= pwdata[15:0];
    end
  end
  assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'd0, timeout_ticks} : {26'd0, slot_count};
  assign win = (slot_count == 6'd0) ? WinBits'(1) :
               (slot_count > 6'(WindowMax)) ? WinBits'(WindowMax) : slot_count;

  srsw_front u_front (.clk, .rst, .valid(in_valid), .ready(in_ready), .in_word,
    .window_base, .win, .cmd_valid, .cmd_ready, .cmd);
  srsw_back u_back (.clk, .rst, .cmd_valid, .cmd_ready, .cmd, .win, .timeout_ticks,
    .window_base, .out_valid, .out_ready, .out_word);

  assign poll_go = cmd_valid && cmd_ready && (cmd.req_type == REQ_POLL);

  `SRSW_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "output word dropped")
  `SRSW_ASSERT(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable(out_word), "word changed")
  `SRSW_ASSERT(a_poll_busy, clk, rst, poll_go |=> !cmd_ready, "poll not started")
  `SRSW_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid && !cmd_valid, "busy after reset")
endmodule

// ===== rtl/core/srsw_front.sv =====
// front end: takes input words, classifies acks against the window, queues commands
module srsw_front (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic ready,
  input  srsw_pkg::in_word_t in_word,
  input  logic [15:0] window_base,
  input  logic [srsw_pkg::WinBits-1:0] win,
  output logic cmd_valid,
  input  logic cmd_ready,
  output srsw_pkg::cmd_t cmd
);
  import srsw_pkg::*;
  cmd_t q [2];
  logic [1:0] count;
  logic wr_ptr, rd_ptr;
  logic [16:0] diff;
  cmd_t c;
  logic push, pop;

  // words are taken only while the back is idle and nothing is queued, so the base is settled
  assign diff = {1'b0, in_word.ack_seq} - {1'b0, window_base};
  always_comb begin
    c.req_type = in_word.req_type;
    c.slot = diff[SlotBits-1:0];
    c.in_window = !diff[16] && (diff[15:0] < {{(16-WinBits){1'b0}}, win})
                  && !in_word.ack_error;
    c.ack_negative = in_word.ack_negative;
    c.buffer_frames = in_word.buffer_frames;
    c.final_buffer = in_word.final_buffer;
  end

  assign ready = (count == 2'd0) && cmd_ready;
  assign push = valid && ready;
  assign cmd_valid = count != 2'd0;
  assign cmd = q[rd_ptr];
  assign pop = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= c;
    if (rst) begin
      count <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== rtl/core/srsw_back.sv =====
// back end: window state, slide and poll scan with output register
module srsw_back (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  srsw_pkg::cmd_t cmd,
  input  logic [srsw_pkg::WinBits-1:0] win,
  input  logic [15:0] timeout_ticks,
  output logic [15:0] window_base,
  output logic out_valid,
  input  logic out_ready,
  output srsw_pkg::out_word_t out_word
);
  import srsw_pkg::*;
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SLIDE = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0] state;
  logic [WindowMax-1:0] sent, acked, overdue;
  logic [31:0] stime [WindowMax];
  logic [15:0] frame_total;
  logic is_final;
  logic [31:0] tick_count;
  logic [WinBits-1:0] idx;
  logic done;
  logic hold_valid;
  out_word_t hold;

  logic [15:0] seq;
  logic [16:0] seq_p1;
  logic [31:0] elapsed;
  logic due, at_end, can_emit, slide_now;
  logic emit, step;
  out_word_t emit_word;

  assign cmd_ready = state == ST_IDLE;
  assign seq = window_base + {{(16-WinBits){1'b0}}, idx};
  assign seq_p1 = {1'b0, seq} + 17'd1;
  assign elapsed = tick_count - stime[idx[SlotBits-1:0]];
  assign at_end = (idx == win) || (seq >= frame_total);
  assign due = !sent[idx[SlotBits-1:0]] || (!acked[idx[SlotBits-1:0]] &&
               (overdue[idx[SlotBits-1:0]] || elapsed > {16'd0, timeout_ticks}));
  assign can_emit = !out_valid || out_ready;
  assign slide_now = acked[0] && (window_base != 16'hFFFF);

  // a pending send word is held back until the next due slot or the end of the scan so last_of_pass can be set on it
  assign emit = (state == ST_SCAN) && can_emit && (at_end || (due && hold_valid));
  assign step = (state == ST_SCAN) && !at_end && (!due || !hold_valid || can_emit);

  always_comb begin
    emit_word = hold;
    if (at_end) begin
      if (hold_valid) begin
        emit_word.last_of_pass = 1'b1;
      end else begin
        emit_word = '{send_valid: 1'b0, send_seq: 16'd0,
          end_of_transmission: 1'b0, last_of_pass: 1'b1, buffer_done: done};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sent <= '0;
      acked <= '0;
      overdue <= '0;
      window_base <= '0;
      frame_total <= '0;
      is_final <= 1'b0;
      tick_count <= '0;
      idx <= '0;
      done <= 1'b0;
      hold_valid <= 1'b0;
      hold <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            case (cmd.req_type)
              REQ_START: begin
                frame_total <= cmd.buffer_frames;
                is_final <= cmd.final_buffer;
                window_base <= '0;
                sent <= '0;
                acked <= '0;
                overdue <= '0;
              end
              REQ_ACK: begin
                if (cmd.in_window) begin
                  if (!cmd.ack_negative) acked[cmd.slot] <= 1'b1;
                  else overdue[cmd.slot] <= 1'b1;
                end
              end
              REQ_TICK: tick_count <= tick_count + 32'd1;
              default: begin
                state <= ST_SLIDE;
                idx <= '0;
              end
            endcase
          end
        end
        ST_SLIDE: begin
          // one slot per cycle while the head is acked, the base is below 16'hFFFF and fewer than win slots have slid
          if (slide_now && (idx != win)) begin
            sent <= sent >> 1;
            acked <= acked >> 1;
            overdue <= overdue >> 1;
            for (int i = 0; i < WindowMax - 1; i++) stime[i] <= stime[i+1];
            window_base <= window_base + 16'd1;
            idx <= idx + WinBits'(1);
          end else begin
            state <= ST_SCAN;
            idx <= '0;
            hold_valid <= 1'b0;
            done <= window_base >= frame_total;
          end
        end
        ST_SCAN: begin
          if (at_end) begin
            if (can_emit) begin
              state <= ST_IDLE;
              hold_valid <= 1'b0;
            end
          end else if (step) begin
            if (due) begin
              sent[idx[SlotBits-1:0]] <= 1'b1;
              overdue[idx[SlotBits-1:0]] <= 1'b0;
              stime[idx[SlotBits-1:0]] <= tick_count;
              hold_valid <= 1'b1;
              hold <= '{send_valid: 1'b1, send_seq: seq,
                end_of_transmission: is_final && (seq_p1 == {1'b0, frame_total}),
                last_of_pass: 1'b0, buffer_done: done};
            end
            idx <= idx + WinBits'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_word <= '0;
    end else if (emit) begin
      out_valid <= 1'b1;
      out_word <= emit_word;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end
endmodule
